[hw/rtl/ppg_pkg.sv]
// Shared types, constants and helper functions for the plasma pixel generator.
// Holds the grid geometry, the stream widths and one square-root digit step.
// No dependencies.
package ppg_pkg;

    // Grid geometry: distances are taken from the centre cell
    localparam int COLUMNS = 64;
    localparam int ROWS    = 64;
    localparam logic [8:0] CENTRE_X = 9'(COLUMNS / 2);
    localparam logic [8:0] CENTRE_Y = 9'(ROWS / 2);

    // Stream widths, padded to whole bytes
    localparam int IN_W  = 24;
    localparam int OUT_W = 32;

    // Number of pipeline stages, output register included
    localparam int NSTG = 10;

    // Phases that ride alongside the distance computation
    typedef struct packed {
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
        logic [7:0] t2;
    } t_carry;

    // Partial state of the digit-by-digit square root
    typedef struct packed {
        logic [8:0] rem;
        logic [7:0] root;
    } t_sq;

    // One restoring square-root step: bring in two radicand bits, try a 1 digit
    function automatic t_sq sqrt_step(t_sq s, logic [1:0] pair);
        logic [10:0] acc;
        logic [10:0] trial;
        t_sq         res;
        acc   = {s.rem, pair};
        trial = {1'b0, s.root, 2'b01};
        if (acc >= trial) begin
            res.rem  = 9'(acc - trial);
            res.root = {s.root[6:0], 1'b1};
        end else begin
            res.rem  = acc[8:0];
            res.root = {s.root[6:0], 1'b0};
        end
        return res;
    endfunction

endpackage

[hw/rtl/plasma_pixel_generator_core.sv]
// Plasma pixel generator: one heat-ramp colour per cell coordinate and frame time.
// An accepted input beat passes through the 10-stage pipeline, whose last stage is
// the output register, to the result beat; throughput is one beat per cycle while
// the sink keeps m_axis_tready high. Each stage holds its beat while the next cannot advance.
// Synchronous active-low reset clears every stage valid bit; payload is not reset.
// Depends on ppg_pkg.
module plasma_pixel_generator_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] pixel_x, [11:6] pixel_y, [19:12] frame_time, [23:20] zero
    input  logic [ppg_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] palette_index, [15:8] red, [23:16] green, [31:24] blue
    output logic [ppg_pkg::OUT_W-1:0] m_axis_tdata
);
    import ppg_pkg::*;

    // Stage valid bits and per-stage advance enables
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;

    // Stage 1: squared offsets and the three direct phases
    logic [14:0] r1_dx2;
    logic [14:0] r1_dy2;
    t_carry      r1_car;

    // Stage 2 (index 0) and the four root stages (index 1..4);
    // the radicand is not registered past the third root stage
    logic [15:0] r_sn  [4];
    t_sq         r_sq  [5];
    t_carry      r_sc  [5];

    // Stage 7: distance phase
    logic [7:0]  r7_p3;
    t_carry      r7_car;

    // Stage 8: wave magnitudes before scaling
    logic [12:0] r8_mag [4];
    logic [3:0]  r8_neg;

    // Stage 9: palette index
    logic [7:0]  r9_idx;

    // Stage 10: output register
    logic [7:0]  r_idx;
    logic [7:0]  r_red;
    logic [7:0]  r_grn;
    logic [7:0]  r_blu;

    // Input field split
    logic [5:0]  w_x;
    logic [5:0]  w_y;
    logic [7:0]  w_t;
    assign w_x = s_axis_tdata[5:0];
    assign w_y = s_axis_tdata[11:6];
    assign w_t = s_axis_tdata[19:12];

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];

    // Valid bits travel with the beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: centre offsets, their squares and the linear phases
    logic signed [8:0] n_dx;
    logic signed [8:0] n_dy;
    logic [7:0]        n_ax;
    logic [7:0]        n_ay;
    t_carry            n_car;
    always_comb begin
        n_dx = $signed({3'b000, w_x}) - $signed(CENTRE_X);
        n_dy = $signed({3'b000, w_y}) - $signed(CENTRE_Y);
        n_ax = n_dx[8] ? 8'(-n_dx) : n_dx[7:0];
        n_ay = n_dy[8] ? 8'(-n_dy) : n_dy[7:0];
        n_car.p0 = 8'({2'b00, w_x} * 8'd5 + w_t);
        n_car.p1 = 8'({2'b00, w_y} * 8'd5 - w_t);
        n_car.p2 = 8'(({2'b00, w_x} + {2'b00, w_y}) * 8'd3 + w_t);
        n_car.t2 = {w_t[6:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_dx2 <= 15'({8'h00, n_ax} * {8'h00, n_ax});
            r1_dy2 <= 15'({8'h00, n_ay} * {8'h00, n_ay});
            r1_car <= n_car;
        end
    end

    // Stage 2: squared distance, root state cleared
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_sn[0] <= 16'(r1_dx2) + 16'(r1_dy2);
            r_sq[0] <= '0;
            r_sc[0] <= r1_car;
        end
    end

    // Stages 3 to 6: two root digits per stage, most significant first
    for (genvar j = 1; j <= 4; j++) begin : g_sqrt
        localparam int HI = 9 - 2 * j;
        localparam int LO = 8 - 2 * j;
        t_sq n_mid;
        t_sq n_out;
        always_comb begin
            n_mid = sqrt_step(r_sq[j-1], r_sn[j-1][2*HI +: 2]);
            n_out = sqrt_step(n_mid,     r_sn[j-1][2*LO +: 2]);
        end
        always_ff @(posedge i_clk) begin
            if (w_en[2+j]) begin
                r_sq[j] <= n_out;
                r_sc[j] <= r_sc[j-1];
            end
        end
        // Pass the radicand on while later root stages still need it
        if (j < 4) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (w_en[2+j]) begin
                    r_sn[j] <= r_sn[j-1];
                end
            end
        end
    end

    // Stage 7: radial phase from the root
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_p3  <= 8'({3'b000, r_sq[4].root} * 11'd6 + {3'b000, r_sc[4].t2});
            r7_car <= r_sc[4];
        end
    end

    // Stage 8: parabola h*(128-h) for each of the four phases
    logic [7:0] w_ph [4];
    assign w_ph[0] = r7_car.p0;
    assign w_ph[1] = r7_car.p1;
    assign w_ph[2] = r7_car.p2;
    assign w_ph[3] = r7_p3;

    for (genvar k = 0; k < 4; k++) begin : g_wave
        logic [14:0] n_prod;
        assign n_prod = {8'h00, w_ph[k][6:0]} * {7'h00, 8'd128 - {1'b0, w_ph[k][6:0]}};
        always_ff @(posedge i_clk) begin
            if (w_en[8]) begin
                r8_mag[k] <= n_prod[12:0];
                r8_neg[k] <= w_ph[k][7];
            end
        end
    end

    // Stage 9: scale, cap, sign, sum and map to the palette
    logic signed [10:0] n_wv [4];
    logic signed [10:0] n_sum;
    logic [7:0]         n_sc;
    always_comb begin
        n_sum = 11'sd512;
        for (int k = 0; k < 4; k++) begin
            n_sc    = 8'(r8_mag[k] >> 5);
            if (n_sc > 8'd127) begin
                n_sc = 8'd127;
            end
            n_wv[k] = r8_neg[k] ? -$signed({3'b000, n_sc}) : $signed({3'b000, n_sc});
            n_sum   = n_sum + n_wv[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r9_idx <= n_sum[9:2];
        end
    end

    // Stage 10: mirrored heat ramp into the output register
    logic [7:0] n_lvl;
    logic [9:0] n_r;
    logic [9:0] n_g;
    logic [9:0] n_b;
    always_comb begin
        n_lvl = r9_idx[7] ? {~r9_idx[6:0], 1'b0} : {r9_idx[6:0], 1'b0};
        priority if (n_lvl < 8'd85) begin
            n_r = 10'(n_lvl) * 10'd3;
            n_g = '0;
            n_b = '0;
        end else if (n_lvl < 8'd170) begin
            n_r = 10'd255;
            n_g = 10'(n_lvl - 8'd85) * 10'd3;
            n_b = '0;
        end else begin
            n_r = 10'd255;
            n_g = 10'd255;
            n_b = 10'(n_lvl - 8'd170) * 10'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_idx <= r9_idx;
            r_red <= (n_r > 10'd255) ? 8'd255 : n_r[7:0];
            r_grn <= (n_g > 10'd255) ? 8'd255 : n_g[7:0];
            r_blu <= (n_b > 10'd255) ? 8'd255 : n_b[7:0];
        end
    end

    assign m_axis_tvalid = r_vld[NSTG];
    assign m_axis_tdata  = {r_blu, r_grn, r_red, r_idx};

endmodule

[tb/plasma_pixel_generator_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for plasma_pixel_generator_core: streams cell coordinates and
// frame times, predicts each heat-ramp colour and compares every result beat.
// Depends on ppg_pkg and the core RTL.
module plasma_pixel_generator_core_tb;
    import ppg_pkg::*;

    // Result beat layout, lowest byte first: palette_index, red, green, blue
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] palette_index;
    } t_colour;

    // Predicts the colour of each accepted cell and matches result beats in order
    class t_heat_colour_board;
        t_colour     pending_q[$];
        int unsigned mismatches;
        int unsigned cells_in;
        int unsigned colours_out;
        int unsigned segment_hits[3];

        // Parabolic sine over one 256-step turn, amplitude 127
        function int parabola(logic [7:0] phase);
            int h;
            int amp;
            h   = phase[6:0];
            amp = (4 * h * (128 - h)) / 128;
            if (amp > 127) begin
                amp = 127;
            end
            return phase[7] ? -amp : amp;
        endfunction

        function t_colour plasma_colour(logic [5:0] x, logic [5:0] y, logic [7:0] t);
            int         dx;
            int         dy;
            int         dist_sq;
            int         radius;
            int         wave_sum;
            int         lvl;
            logic [7:0] idx;
            t_colour    c;
            // Floor square root of the squared distance from the grid centre
            dx      = int'(x) - COLUMNS / 2;
            dy      = int'(y) - ROWS / 2;
            dist_sq = dx * dx + dy * dy;
            radius  = 0;
            while ((radius + 1) * (radius + 1) <= dist_sq) begin
                radius++;
            end
            // Sum four waves; every phase wraps at 256, the falling one too
            wave_sum = parabola(8'(x * 5 + t))
                     + parabola(8'(y * 5 - t))
                     + parabola(8'((x + y) * 3 + t))
                     + parabola(8'(radius * 6 + t * 2));
            idx = 8'((wave_sum + 512) >> 2);
            // Mirrored heat ramp; channels top out at 252, so no clamp bites
            lvl = idx[7] ? 2 * (255 - int'(idx)) : 2 * int'(idx);
            c.palette_index = idx;
            if (lvl < 85) begin
                c.red   = 8'(3 * lvl);
                c.green = 8'd0;
                c.blue  = 8'd0;
                segment_hits[0]++;
            end else if (lvl < 170) begin
                c.red   = 8'd255;
                c.green = 8'(3 * (lvl - 85));
                c.blue  = 8'd0;
                segment_hits[1]++;
            end else begin
                c.red   = 8'd255;
                c.green = 8'd255;
                c.blue  = 8'(3 * (lvl - 170));
                segment_hits[2]++;
            end
            return c;
        endfunction

        function void note_cell(logic [5:0] x, logic [5:0] y, logic [7:0] t);
            pending_q.push_back(plasma_colour(x, y, t));
            cells_in++;
        endfunction

        function void check_colour(logic [OUT_W-1:0] data);
            string      field_name[4] = '{"palette_index", "red", "green", "blue"};
            logic [31:0] want;
            colours_out++;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat %h with no colour pending", $time, data);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            for (int f = 0; f < 4; f++) begin
                if (data[8*f +: 8] !== want[8*f +: 8]) begin
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                             field_name[f], want[8*f +: 8], data[8*f +: 8]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // [5:0] pixel_x, [11:6] pixel_y, [19:12] frame_time, [23:20] zero
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // [7:0] palette_index, [15:8] red, [23:16] green, [31:24] blue
    logic [OUT_W-1:0] m_axis_tdata;

    t_heat_colour_board board = new;
    int                 src_idle_pct  = 0;
    int                 sink_idle_pct = 0;

    plasma_pixel_generator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Check every accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_colour(m_axis_tdata);
        end
    end

    // Offer one cell beat, idling first at the current rate; return at a falling edge
    task automatic push_cell(input logic [5:0] x, input logic [5:0] y, input logic [7:0] t);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_W'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, t, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        board.note_cell(x, y, t);
        @(negedge i_clk);
    endtask

    // Hold off the input until every pending colour has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (board.pending_q.size() != 0);
    endtask

    // Corners, the centre cell, the wrapping falling phase and assorted mid points
    task automatic run_directed();
        int cx[17] = '{0, 63, 0, 63, 32, 32, 32, 31, 0, 0, 63, 0, 21, 42, 1, 62, 16};
        int cy[17] = '{0, 63, 63, 0, 32, 32, 32, 33, 0, 1, 63, 0, 42, 21, 2, 61, 48};
        int ct[17] = '{0, 255, 0, 255, 0, 128, 255, 64, 1, 200, 0, 255, 170, 85, 4, 127, 129};
        for (int i = 0; i < 17; i++) begin
            push_cell(6'(cx[i]), 6'(cy[i]), 8'(ct[i]));
        end
    endtask

    // Mix short raster runs along a row with scattered cells
    task automatic run_random(input int count, input int src_pct, input int sink_pct);
        int         n;
        int         run_len;
        logic [5:0] x0;
        logic [5:0] row;
        logic [7:0] t;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 1) == 1) begin
                x0      = 6'($urandom_range(0, 63));
                row     = 6'($urandom_range(0, 63));
                t       = 8'($urandom_range(0, 255));
                run_len = $urandom_range(2, 12);
                for (int k = 0; k < run_len && n < count; k++) begin
                    push_cell(6'(x0 + k), row, t);
                    n++;
                end
            end else begin
                push_cell(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
                n++;
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 11;
        sink_idle_pct = 84;
        run_directed();
        hold_until_drained();
        run_random(300, 11, 84);
        hold_until_drained();
        run_random(300, 84, 11);
        hold_until_drained();
        run_random(300, 0, 0);

        // Drain, then wait on for any stray beats
        s_axis_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NSTG + 10) @(posedge i_clk);

        $display("Sent %0d cells under three pacing regimes; %0d colours checked.",
                 board.cells_in, board.colours_out);
        $display("Heat ramp segments reached: red %0d, yellow %0d, white %0d.",
                 board.segment_hits[0], board.segment_hits[1], board.segment_hits[2]);
        if (board.mismatches == 0 && board.pending_q.size() == 0) begin
            $display("plasma_pixel_generator_core verification clean");
        end else begin
            $display("plasma_pixel_generator_core verification failed");
        end
        $finish;
    end

    // Give up on a hung handshake
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d colours pending", $time, board.pending_q.size());
        $display("plasma_pixel_generator_core verification failed");
        $finish;
    end

endmodule

[plasma_pixel_generator_core.f]
hw/rtl/ppg_pkg.sv
hw/rtl/plasma_pixel_generator_core.sv
tb/plasma_pixel_generator_core_tb.sv
